### hdl/rpn_pkg.sv
// Shared types and constants for the reverse Polish evaluator.
// No dependencies; used by rpn_div, rpn_stack_evaluator_top and the testbench.
`timescale 1ns / 1ps

package rpn_pkg;

    localparam int VALUE_WIDTH     = 32;
    localparam int STACK_DEPTH_DEF = 64;

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNDER   = 3'd1;
    localparam logic [2:0] ST_COUNT   = 3'd2;
    localparam logic [2:0] ST_DIVZERO = 3'd3;
    localparam logic [2:0] ST_OVER    = 3'd4;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic [2:0]                    status;
    } t_out_item;

endpackage

### hdl/rpn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/rpn_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rpn_pkg for the default width.
`timescale 1ns / 1ps

module rpn_div #(
    parameter int WIDTH = rpn_pkg::VALUE_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient
);

    localparam int CNT_W = $clog2(WIDTH);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [WIDTH:0]   r_rem, n_rem;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_den, n_den;
    logic             r_neg, n_neg;
    logic [WIDTH:0]   rem_shift;
    logic [WIDTH:0]   diff;

    assign rem_shift = {r_rem[WIDTH-1:0], r_quo[WIDTH-1]};
    assign diff      = rem_shift - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_dividend[WIDTH-1] ? (~i_dividend + 1'b1) : i_dividend;
            n_den  = i_divisor[WIDTH-1] ? (~i_divisor + 1'b1) : i_divisor;
            n_neg  = i_dividend[WIDTH-1] ^ i_divisor[WIDTH-1];
        end else if (r_busy) begin
            // restoring step
            if (!diff[WIDTH]) begin
                n_rem = diff;
            end else begin
                n_rem = rem_shift;
            end
            n_quo = {r_quo[WIDTH-2:0], ~diff[WIDTH]};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(WIDTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

    ap_no_start_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    ap_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy))
        else $error("divider done without a running division");

endmodule

### hdl/rpn_stack_evaluator_top.sv
// Reverse Polish evaluator: stack in a RAM, top entry held in a register.
// Depends on rpn_pkg, rpn_ram and rpn_div.
// Digits and ignored characters are taken in the idle state; + - * read the
// second entry from the RAM, then execute; / then runs the bit-serial divider.
// A last character then passes through the finish state to load the output register.
// Reset (synchronous, active low) clears count, error and handshakes; the RAM is not cleared.
`timescale 1ns / 1ps

module rpn_stack_evaluator_top #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  rpn_pkg::t_in_item   i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output rpn_pkg::t_out_item  o_out_item,
    input  logic                i_out_stall
);

    localparam int VW = rpn_pkg::VALUE_WIDTH;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [2:0]         r_err, n_err;
    logic [VW-1:0]      r_top, n_top;
    logic [7:0]         r_ch, n_ch;
    logic               r_last, n_last;
    logic               r_out_valid, n_out_valid;
    rpn_pkg::t_out_item r_out, n_out;

    logic          in_acc;
    logic          is_digit, is_op;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [VW-1:0] ram_rdata;
    logic          div_start, div_done;
    logic [VW-1:0] div_q;
    logic [2:0]    fin_status;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign is_digit = i_in_item.ch inside {[rpn_pkg::CH_ZERO:rpn_pkg::CH_NINE]};
    assign is_op    = i_in_item.ch inside {rpn_pkg::CH_PLUS, rpn_pkg::CH_MINUS,
                                           rpn_pkg::CH_STAR, rpn_pkg::CH_SLASH};

    // old top goes to the RAM on a push; the second entry is read for an operator
    assign ram_waddr = AW'(r_count - 1'b1);
    assign ram_raddr = AW'(r_count - CW'(2));

    assign fin_status = (r_err != rpn_pkg::ST_OK) ? r_err :
                        (r_count != CW'(1))       ? rpn_pkg::ST_COUNT : rpn_pkg::ST_OK;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_err       = r_err;
        n_top       = r_top;
        n_ch        = r_ch;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        div_start   = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_ch   = i_in_item.ch;
                    n_last = i_in_item.last;
                    if (r_err == rpn_pkg::ST_OK) begin
                        if (is_digit) begin
                            if (r_count == CW'(STACK_DEPTH)) begin
                                n_err = rpn_pkg::ST_OVER;
                            end else begin
                                ram_we  = (r_count != '0);
                                n_top   = VW'(i_in_item.ch - rpn_pkg::CH_ZERO);
                                n_count = r_count + 1'b1;
                            end
                        end else if (is_op) begin
                            if (r_count < CW'(2)) begin
                                n_err = rpn_pkg::ST_UNDER;
                            end else begin
                                ram_re  = 1'b1;
                                n_state = S_EXEC;
                            end
                        end
                    end
                    if (n_state == S_IDLE && i_in_item.last) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_EXEC: begin
                // ram_rdata is the entry below the top, r_top is the top
                n_state = r_last ? S_FIN : S_IDLE;
                case (r_ch)
                    rpn_pkg::CH_PLUS: begin
                        n_top   = ram_rdata + r_top;
                        n_count = r_count - 1'b1;
                    end
                    rpn_pkg::CH_MINUS: begin
                        n_top   = ram_rdata - r_top;
                        n_count = r_count - 1'b1;
                    end
                    rpn_pkg::CH_STAR: begin
                        n_top   = ram_rdata * r_top;
                        n_count = r_count - 1'b1;
                    end
                    rpn_pkg::CH_SLASH: begin
                        if (r_top == '0) begin
                            n_err = rpn_pkg::ST_DIVZERO;
                        end else begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end
                    end
                    default: begin
                        n_state = r_last ? S_FIN : S_IDLE;
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    n_top   = div_q;
                    n_count = r_count - 1'b1;
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out.status = fin_status;
                    n_out.value  = (fin_status == rpn_pkg::ST_OK) ? r_top : '0;
                    n_count      = '0;
                    n_err        = rpn_pkg::ST_OK;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_err       <= rpn_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
        r_top  <= n_top;
        r_ch   <= n_ch;
        r_last <= n_last;
        r_out  <= n_out;
    end

    rpn_ram #(
        .WIDTH (VW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_top),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rpn_div #(
        .WIDTH (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (ram_rdata),
        .i_divisor  (r_top),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    ap_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("entry count beyond stack depth");

    ap_exec_two_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> (r_count >= CW'(2)))
        else $error("operator executing with fewer than two entries");

    ap_error_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != rpn_pkg::ST_OK) |-> (o_out_item.value == '0))
        else $error("nonzero value with error status");

    ap_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(r_out_valid) && r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result loaded outside the finish state");

endmodule

### dv/tb_rpn_stack_evaluator_top.sv
// Self-checking testbench for rpn_stack_evaluator_top: directed and random character streams.
// Depends on rpn_pkg and the evaluator RTL; expected results come from a behavioral stack model.
`timescale 1ns / 1ps

module tb_rpn_stack_evaluator_top;

    localparam int VW         = rpn_pkg::VALUE_WIDTH;
    localparam int DEPTH      = rpn_pkg::STACK_DEPTH_DEF;
    localparam int LONG_HOLD  = 300;
    localparam int WDOG_LIMIT = 2000;
    localparam int DRAIN_WAIT = 50;   // worst case divide plus output load, with margin
    localparam int MAX_PRINTS = 50;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    rpn_pkg::t_in_item  in_item = '0;
    logic               in_stall;
    logic               out_valid;
    rpn_pkg::t_out_item out_item;
    logic               out_stall = 1'b0;

    rpn_stack_evaluator_top #(.STACK_DEPTH(DEPTH)) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall)
    );

    always #5 clk = ~clk;

    // stack mirror
    logic [VW-1:0] stack_mirror [DEPTH];
    int unsigned   live_cnt = 0;
    logic [2:0]    err_code = rpn_pkg::ST_OK;

    rpn_pkg::t_out_item pending_results [$];

    bit send_idle_on = 1'b0;
    bit recv_idle_on = 1'b0;
    bit hold_req     = 1'b0;

    int mismatches = 0;
    int chars_sent = 0;
    int results_seen = 0;
    int status_hits [5];
    int quiet_cycles = 0;

    function automatic bit is_operator(input logic [7:0] ch);
        return ch == rpn_pkg::CH_PLUS || ch == rpn_pkg::CH_MINUS ||
               ch == rpn_pkg::CH_STAR || ch == rpn_pkg::CH_SLASH;
    endfunction

    function automatic bit is_digit(input logic [7:0] ch);
        return ch >= rpn_pkg::CH_ZERO && ch <= rpn_pkg::CH_NINE;
    endfunction

    // Applies one character to the mirror; a result comes out only when last is set.
    function automatic void rpn_eval_char(input logic [7:0] ch, input logic last,
                                          output bit has_res,
                                          output rpn_pkg::t_out_item res);
        logic [VW-1:0] a, b, r, mag_a, mag_b;
        has_res = 1'b0;
        res = '0;
        if (err_code == rpn_pkg::ST_OK) begin
            if (is_digit(ch)) begin
                if (live_cnt >= DEPTH) begin
                    err_code = rpn_pkg::ST_OVER;
                end else begin
                    stack_mirror[live_cnt] = VW'(ch - rpn_pkg::CH_ZERO);
                    live_cnt++;
                end
            end else if (is_operator(ch)) begin
                if (live_cnt < 2) begin
                    err_code = rpn_pkg::ST_UNDER;
                end else begin
                    b = stack_mirror[live_cnt-1];
                    a = stack_mirror[live_cnt-2];
                    r = '0;
                    case (ch)
                        rpn_pkg::CH_PLUS:  r = a + b;
                        rpn_pkg::CH_MINUS: r = a - b;
                        rpn_pkg::CH_STAR:  r = a * b;
                        default: begin
                            if (b == '0) begin
                                err_code = rpn_pkg::ST_DIVZERO;
                            end else begin
                                // magnitudes as unsigned, so the most negative value works
                                mag_a = a[VW-1] ? -a : a;
                                mag_b = b[VW-1] ? -b : b;
                                r = mag_a / mag_b;
                                if (a[VW-1] ^ b[VW-1]) r = -r;
                            end
                        end
                    endcase
                    if (err_code == rpn_pkg::ST_OK) begin
                        stack_mirror[live_cnt-2] = r;
                        live_cnt--;
                    end
                end
            end
        end
        if (last) begin
            has_res = 1'b1;
            if (err_code != rpn_pkg::ST_OK) res.status = err_code;
            else if (live_cnt != 1) res.status = rpn_pkg::ST_COUNT;
            else res.status = rpn_pkg::ST_OK;
            if (res.status == rpn_pkg::ST_OK) res.value = stack_mirror[0];
            live_cnt = 0;
            err_code = rpn_pkg::ST_OK;
        end
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Drives one item; returns at the edge where it is taken.
    task automatic send_char(input logic [7:0] ch, input logic last);
        int gap;
        bit has_res;
        rpn_pkg::t_out_item res;
        @(negedge clk);
        if (send_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item.ch = ch;
        in_item.last = last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        rpn_eval_char(ch, last, has_res, res);
        if (has_res) pending_results.push_back(res);
        chars_sent++;
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_expr(input logic [7:0] chars [$]);
        foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
    endtask

    // Input goes quiet until every expected result is in, then the block settles.
    task automatic wait_drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_digit(c) || is_operator(c));
        return c;
    endfunction

    function automatic logic [7:0] rand_op();
        case ($urandom_range(0, 3))
            0: return rpn_pkg::CH_PLUS;
            1: return rpn_pkg::CH_MINUS;
            2: return rpn_pkg::CH_STAR;
            default: return rpn_pkg::CH_SLASH;
        endcase
    endfunction

    // Well-formed expression with random digits and operators, noise sprinkled in.
    function automatic void build_good_expr(ref logic [7:0] chars [$], input int operands);
        int d = 0;
        int pushed = 0;
        chars.delete();
        while (pushed < operands || d > 1) begin
            if (pushed < operands && (d < 2 || $urandom_range(0, 1) == 0)) begin
                chars.push_back(rpn_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                d++;
                pushed++;
            end else begin
                chars.push_back(rand_op());
                d--;
            end
            if ($urandom_range(0, 7) == 0) chars.push_back(noise_char());
        end
    endfunction

    function automatic void build_bad_expr(ref logic [7:0] chars [$]);
        int n = $urandom_range(1, 10);
        chars.delete();
        repeat (n) begin
            case ($urandom_range(0, 2))
                0: chars.push_back(rpn_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                1: chars.push_back(rand_op());
                default: chars.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    task automatic test_basic_ops();
        send_string("34+");
        send_string("95-");
        send_string("78*");
        send_string("92/");
        send_string("09-4/");   // negative quotient truncates toward zero
        send_string("8 ");      // ignored character carries the last flag
        send_string("12 + ");
    endtask

    task automatic test_error_cases();
        send_string("+");       // operator on empty stack
        send_string("5+");      // operator with one entry
        send_string("50/");     // divide by zero
        send_string("12");      // two entries left
        send_string(" ");       // empty expression
        send_string("+12+");    // characters after an error are ignored
        send_string("05-0/3");
    endtask

    task automatic test_wrap_extremes();
        string s;
        s = "8";
        repeat (9) s = {s, "8*"};
        send_string({s, "2*01-/"});   // most negative value divided by -1
        send_string({s, "2*1-"});     // wraps to the most positive value
        send_string("99*9*9*9*9*9*9*9*9*9*9*");
    endtask

    task automatic test_stack_limits();
        logic [7:0] chars [$];
        // fill to the brim, then fold back down
        repeat (DEPTH) chars.push_back(rpn_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
        repeat (DEPTH - 1) chars.push_back(rpn_pkg::CH_PLUS);
        send_expr(chars);
        chars.delete();
        repeat (DEPTH + 1) chars.push_back(rpn_pkg::CH_NINE);
        chars.push_back(rpn_pkg::CH_PLUS);
        send_expr(chars);
    endtask

    task automatic test_backpressure();
        wait_drain();
        hold_req = 1'b1;
        repeat (40) send_char(rpn_pkg::CH_ZERO + 8'($urandom_range(0, 9)), 1'b1);
        wait_drain();
    endtask

    task automatic test_random(input int n_chars);
        logic [7:0] chars [$];
        int stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at) begin
            case ($urandom_range(0, 19))
                0, 1, 2:  build_bad_expr(chars);
                3:        build_good_expr(chars, $urandom_range(30, DEPTH + 2));
                default:  build_good_expr(chars, $urandom_range(1, 10));
            endcase
            send_expr(chars);
        end
    endtask

    // result checker
    always @(posedge clk) begin
        rpn_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value=%0d status=%0d",
                                          out_item.value, out_item.status));
            end else begin
                want = pending_results.pop_front();
                if (out_item.status <= rpn_pkg::ST_OVER) status_hits[out_item.status]++;
                if (out_item.value !== want.value)
                    report_mismatch($sformatf("value got %0d want %0d",
                                              out_item.value, want.value));
                if (out_item.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              out_item.status, want.status));
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_LIMIT) begin
            $display("[%0t] watchdog: no handshake for %0d cycles", $time, WDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver stall control
    initial begin : recv_ctrl
        int n;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall = 1'b0;
                hold_req = 1'b0;
            end else if (recv_idle_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 10);
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    initial begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_basic_ops();
        test_error_cases();
        test_wrap_extremes();
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        test_stack_limits();
        test_backpressure();
        test_random(1300);
        wait_drain();
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        test_random(250);

        wait_drain();
        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("Covered %0d characters and %0d results, with stalls on both sides.",
                 chars_sent, results_seen);
        $display("Status mix: ok %0d, underflow %0d, count %0d, div-by-zero %0d, overflow %0d",
                 status_hits[rpn_pkg::ST_OK], status_hits[rpn_pkg::ST_UNDER],
                 status_hits[rpn_pkg::ST_COUNT], status_hits[rpn_pkg::ST_DIVZERO],
                 status_hits[rpn_pkg::ST_OVER]);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
